FILE: rtl/core/lpse_pkg.sv
// lpse_pkg: shared types and constants of the led pixel spi encoder
// no dependencies
package lpse_pkg;

  localparam int CHAN_W      = 8;
  localparam int BRIGHT_W    = 9;
  localparam int LEVEL_W     = 8;
  localparam int PIXEL_W     = 3 * CHAN_W;
  localparam int PROD1_W     = CHAN_W + BRIGHT_W;
  localparam int PROD2_W     = PROD1_W + LEVEL_W;
  localparam int WORD_W      = 16;
  localparam int WORDS_PER_PIXEL = PIXEL_W;
  localparam int CNT_W       = $clog2(WORDS_PER_PIXEL);
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 3;

  localparam logic [WORD_W-1:0] WORD_ONE  = 16'h7f00;
  localparam logic [WORD_W-1:0] WORD_ZERO = 16'h7000;
  localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(WORDS_PER_PIXEL - 1);

  localparam logic REG_BRIGHTNESS = 1'b0;
  localparam logic REG_MAX_LEVEL  = 1'b1;

  localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 9'd256;
  localparam logic [LEVEL_W-1:0]  LEVEL_RESET  = 8'd255;

  // dimmed pixel in wire order
  typedef struct packed {
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] b;
  } dim_t;

endpackage

FILE: rtl/core/led_pixel_spi_encoder_core.sv
// led_pixel_spi_encoder_core: top level with config registers, front, queue, back
// depends on lpse_pkg, lpse_front, lpse_queue, lpse_back
//
// Each pushed 24-bit rgb pixel is dimmed by brightness (256 = full) and
// max_level, reordered green, red, blue and popped as 24 sixteen-bit spi
// words, 0x7f00 for a one bit and 0x7000 for a zero, the 24th flagged by
// last_word. The serializer hands out one word per pop and loads the next
// queued pixel as the last word is taken, so a steady stream leaves no gap
// between pixels; a pixel reaches the output through the two multiply stages,
// the queue and the serializer register. A two-stage multiply pipeline and a
// two-pixel queue let new pixels be taken while earlier words are still popped.
// Registers: brightness at 0x0 (9 bits), max_level at 0x4 (8 bits).
module led_pixel_spi_encoder_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [lpse_pkg::PIXEL_W-1:0]  in_pixel_rgb,
  input  logic                          pop,
  output logic                          empty,
  output logic [lpse_pkg::WORD_W-1:0]   out_spi_word,
  output logic                          out_last_word,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lpse_pkg::ADDR_W-1:0]   paddr,
  input  logic [lpse_pkg::DATA_W-1:0]   pwdata,
  output logic [lpse_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import lpse_pkg::*;

  logic [BRIGHT_W-1:0] brightness_r;
  logic [LEVEL_W-1:0]  max_level_r;
  logic                wr;
  logic                q_push, q_full, q_pop, q_empty;
  dim_t                q_wdata, q_rdata;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= BRIGHT_RESET;
      max_level_r  <= LEVEL_RESET;
    end else if (wr) begin
      case (paddr[2])
        REG_BRIGHTNESS: brightness_r <= pwdata[BRIGHT_W-1:0];
        REG_MAX_LEVEL:  max_level_r  <= pwdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_BRIGHTNESS: prdata = DATA_W'(brightness_r);
      REG_MAX_LEVEL:  prdata = DATA_W'(max_level_r);
      default:        prdata = '0;
    endcase
  end

  lpse_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .pixel      (in_pixel_rgb),
    .brightness (brightness_r),
    .max_level  (max_level_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  lpse_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  lpse_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .pop       (pop),
    .empty     (empty),
    .spi_word  (out_spi_word),
    .last_word (out_last_word)
  );

endmodule

FILE: rtl/core/lpse_front.sv
// lpse_front: accepts pixels and dims each channel in a short pipeline
// depends on lpse_pkg
module lpse_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  logic [lpse_pkg::PIXEL_W-1:0]    pixel,
  input  logic [lpse_pkg::BRIGHT_W-1:0]   brightness,
  input  logic [lpse_pkg::LEVEL_W-1:0]    max_level,
  input  logic                            q_full,
  output logic                            q_push,
  output lpse_pkg::dim_t                  q_data
);
  import lpse_pkg::*;

  // floor(p / 65280) saturated to 255
  function automatic logic [CHAN_W-1:0] dim_div(input logic [PROD2_W-1:0] p);
    logic [PROD2_W-9:0] q;
    logic [CHAN_W-1:0]  e;
    logic [15:0]        rem;
    logic [CHAN_W-1:0]  res;
    q = p[PROD2_W-1:8];
    e = q[15:8];
    rem = q[15:0] - {e, 8'h00} + {8'h00, e};
    if (q >= 17'd65280) begin
      res = 8'hff;
    end else if (rem >= 16'd255) begin
      res = e + 8'd1;
    end else begin
      res = e;
    end
    return res;
  endfunction

  logic                 v1_r, v2_r;
  logic                 adv, acc;
  logic [PROD1_W-1:0]   prod1_r [3];
  logic [PROD2_W-1:0]   prod2_r [3];
  logic [CHAN_W-1:0]    chan [3];

  assign adv  = !v2_r || !q_full;
  assign full = !adv;
  assign acc  = push && adv;

  // lane 0 green, 1 red, 2 blue
  assign chan[0] = pixel[15:8];
  assign chan[1] = pixel[23:16];
  assign chan[2] = pixel[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= acc;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (acc) begin
        prod1_r[i] <= PROD1_W'(chan[i]) * PROD1_W'(brightness);
      end
      if (adv && v1_r) begin
        prod2_r[i] <= PROD2_W'(prod1_r[i]) * PROD2_W'(max_level);
      end
    end
  end

  assign q_push   = v2_r && !q_full;
  assign q_data.g = dim_div(prod2_r[0]);
  assign q_data.r = dim_div(prod2_r[1]);
  assign q_data.b = dim_div(prod2_r[2]);

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full && v2_r |=> v2_r)
    else $error("dimmed pixel dropped while queue full");

endmodule

FILE: rtl/core/lpse_queue.sv
// lpse_queue: short queue of dimmed pixels between front and back
// depends on lpse_pkg
module lpse_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  lpse_pkg::dim_t  wr_data,
  output logic            full,
  input  logic            rd_en,
  output lpse_pkg::dim_t  rd_data,
  output logic            empty
);
  import lpse_pkg::*;

  dim_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) begin
        wp_r <= (wp_r == QPTR_W'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (rd_en) begin
        rp_r <= (rp_r == QPTR_W'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !full || rd_en)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> cnt_r != '0)
    else $error("queue read while empty");

endmodule

FILE: rtl/core/lpse_back.sv
// lpse_back: serializes a dimmed pixel into 24 spi words, msb first
// depends on lpse_pkg
module lpse_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  lpse_pkg::dim_t                q_data,
  output logic                          q_pop,
  input  logic                          pop,
  output logic                          empty,
  output logic [lpse_pkg::WORD_W-1:0]   spi_word,
  output logic                          last_word
);
  import lpse_pkg::*;

  logic [PIXEL_W-1:0] sh_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               take, done, ld;

  assign take = pop && busy_r;
  assign done = take && (cnt_r == CNT_LAST);
  assign ld   = (!busy_r || done) && !q_empty;

  assign q_pop     = ld;
  assign empty     = !busy_r;
  assign spi_word  = sh_r[PIXEL_W-1] ? WORD_ONE : WORD_ZERO;
  assign last_word = (cnt_r == CNT_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (ld) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (take) begin
      cnt_r <= cnt_r + 1'b1;
      if (done) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      sh_r <= q_data;
    end else if (take) begin
      sh_r <= {sh_r[PIXEL_W-2:0], 1'b0};
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r <= CNT_LAST)
    else $error("word counter past last word");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    done && q_empty |=> !busy_r)
    else $error("serializer busy after last word with nothing queued");

endmodule

FILE: dv/tb_led_pixel_spi_encoder_core.sv
// tb_led_pixel_spi_encoder_core: self-checking testbench of the led pixel spi encoder core
// drives pixels and register writes, predicts the 24 spi words of each pixel and checks them
// depends on lpse_pkg and led_pixel_spi_encoder_core
module tb_led_pixel_spi_encoder_core;
  timeunit 1ns;
  timeprecision 1ps;

  import lpse_pkg::*;

  localparam logic [ADDR_W-1:0] ADDR_BRIGHTNESS = 3'h0;
  localparam logic [ADDR_W-1:0] ADDR_MAX_LEVEL  = 3'h4;
  localparam int unsigned SCALE_DIV   = 65280;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          HOLD_CYCLES = 150;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } spi_word_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                push = 1'b0;
  logic                full;
  logic [PIXEL_W-1:0]  in_pixel_rgb = '0;
  logic                pop = 1'b0;
  logic                empty;
  logic [WORD_W-1:0]   out_spi_word;
  logic                out_last_word;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  logic [PIXEL_W-1:0]  pixel_queue[$];
  spi_word_t           expected_words[$];
  logic [BRIGHT_W-1:0] bright_cfg = BRIGHT_RESET;
  logic [LEVEL_W-1:0]  level_cfg = LEVEL_RESET;
  bit                  calm = 1'b0;
  int                  mismatches = 0;
  int                  pixels_sent = 0;
  int                  words_seen = 0;
  int                  settings_used = 0;
  int                  hold_left = 0;
  int                  cycle_count = 0;

  led_pixel_spi_encoder_core DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_pixel_rgb  (in_pixel_rgb),
    .pop           (pop),
    .empty         (empty),
    .out_spi_word  (out_spi_word),
    .out_last_word (out_last_word),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [CHAN_W-1:0] dim_level(input logic [CHAN_W-1:0] c);
    int unsigned scaled;
    scaled = (int'(c) * int'(bright_cfg) * int'(level_cfg)) / SCALE_DIV;
    return (scaled > 255) ? 8'd255 : scaled[CHAN_W-1:0];
  endfunction

  task automatic encode_pixel(input logic [PIXEL_W-1:0] px);
    dim_t      stream;
    spi_word_t w;
    stream.r = dim_level(px[23:16]);
    stream.g = dim_level(px[15:8]);
    stream.b = dim_level(px[7:0]);
    for (int k = 0; k < WORDS_PER_PIXEL; k++) begin
      w.word = stream[WORDS_PER_PIXEL-1-k] ? WORD_ONE : WORD_ZERO;
      w.last = (k == WORDS_PER_PIXEL - 1);
      expected_words.push_back(w);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else if (!(push && full)) begin
      if (push) begin
        encode_pixel(in_pixel_rgb);
        pixels_sent++;
      end
      if (pixel_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 10)) begin
        push <= 1'b1;
        in_pixel_rgb <= pixel_queue.pop_front();
      end else begin
        push <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    spi_word_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word %h last %b", $time, out_spi_word, out_last_word);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          if (out_spi_word !== want.word) begin
            $display("%0t: spi_word expected %h actual %h", $time, want.word, out_spi_word);
            mismatches++;
          end
          if (out_last_word !== want.last) begin
            $display("%0t: last_word expected %b actual %b", $time, want.last, out_last_word);
            mismatches++;
          end
        end
        words_seen++;
        if (words_seen == 1000 || words_seen == 2600) hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= calm || $urandom_range(0, 99) >= 10;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_led_pixel_spi_encoder_core failed");
    $finish;
  end

  task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] data, output logic [DATA_W-1:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_register(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] got;
    apb_access(1'b1, addr, value, got);
    apb_access(1'b0, addr, '0, got);
    if (got !== value) begin
      $display("%0t: readback at %h expected %h actual %h", $time, addr, value, got);
      mismatches++;
    end
  endtask

  task automatic set_levels(input int unsigned b, input int unsigned m);
    bright_cfg = b[BRIGHT_W-1:0];
    level_cfg = m[LEVEL_W-1:0];
    set_register(ADDR_BRIGHTNESS, DATA_W'(bright_cfg));
    set_register(ADDR_MAX_LEVEL, DATA_W'(level_cfg));
    settings_used++;
  endtask

  // sampled at the falling edge so the driver's updates of the rising edge have settled
  task automatic wait_drained();
    while (pixel_queue.size() != 0 || push || expected_words.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [CHAN_W-1:0] rand_channel();
    case ($urandom_range(0, 4))
      0: return 8'h00;
      1: return 8'hff;
      2: return 8'h80;
      3: return 8'h7f;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic random_pixels(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 70) pixel_queue.push_back(PIXEL_W'($urandom));
      else pixel_queue.push_back({rand_channel(), rand_channel(), rand_channel()});
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset levels, channel extremes and bit patterns
    pixel_queue = '{24'h000000, 24'hffffff, 24'hff0000, 24'h00ff00, 24'h0000ff,
                    24'h800000, 24'h010101, 24'h7f7f7f, 24'haa55aa, 24'h55aa55, 24'h123456};
    settings_used++;
    wait_drained();

    // zero settings give all zero words
    set_levels(0, 255);
    pixel_queue = '{24'hffffff, 24'h808080, 24'h123456};
    wait_drained();
    set_levels(256, 0);
    pixel_queue = '{24'hffffff, 24'h00ff00, 24'ha5a5a5};
    wait_drained();

    // brightness above full, which saturates the larger channels at 511
    set_levels(511, 255);
    pixel_queue = '{24'hffffff, 24'h808080, 24'h404040, 24'h7f8081};
    wait_drained();
    set_levels(300, 200);
    pixel_queue = '{24'hff00ff, 24'h0f0f0f, 24'hc3c3c3};
    wait_drained();

    calm = 1'b1;
    set_levels(256, 255);
    random_pixels(24);
    wait_drained();
    calm = 1'b0;
    set_levels($urandom_range(0, 511), $urandom_range(0, 255));
    random_pixels(24);
    wait_drained();
    set_levels($urandom_range(200, 511), $urandom_range(128, 255));
    random_pixels(24);
    wait_drained();
    set_levels(256, $urandom_range(0, 255));
    random_pixels(24);
    wait_drained();

    mismatches += expected_words.size();
    $display("%0d pixels over %0d level settings, %0d spi words checked, %0d mismatches",
             pixels_sent, settings_used, words_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb_led_pixel_spi_encoder_core passed");
    end else begin
      $display("tb_led_pixel_spi_encoder_core failed");
    end
    $finish;
  end

endmodule
